[rtl/bcc_pkg.sv]
// Shared types, constants and helpers for the button click classifier.
package bcc_pkg;

    localparam int TIME_BITS = 32;
    localparam int MS_BITS   = 16;
    localparam int NOW_BITS  = 32;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [MS_BITS-1:0]   ms_t;

    typedef enum logic [1:0] {
        EV_SHORT  = 2'd0,
        EV_LONG   = 2'd1,
        EV_DOUBLE = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        REG_DEBOUNCE_MS   = 2'd0,
        REG_LONG_PRESS_MS = 2'd1,
        REG_DOUBLE_MS     = 2'd2,
        REG_DOUBLE_EN     = 2'd3
    } reg_index_t;

    typedef struct packed {
        ms_t  debounce_ms;
        ms_t  long_press_ms;
        ms_t  double_click_ms;
        logic double_click_enable;
    } cfg_t;

    // Timestamp port value to internal time width (zero above, truncated below).
    function automatic time_t now_to_time(input logic [NOW_BITS-1:0] v);
        logic [63:0] wide;
        wide = {{(64-NOW_BITS){1'b0}}, v};
        return wide[TIME_BITS-1:0];
    endfunction

    // Millisecond setting widened to the time width for compares.
    function automatic time_t ms_to_time(input ms_t v);
        return {{(TIME_BITS-MS_BITS){1'b0}}, v};
    endfunction

endpackage

[rtl/bcc_cfg_regs.sv]
// Configuration register bank with reset defaults.
module bcc_cfg_regs (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  bcc_pkg::reg_index_t      cfg_addr,
    input  logic [bcc_pkg::MS_BITS-1:0] cfg_wr_data,
    output bcc_pkg::cfg_t            cfg
);
    import bcc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms         <= ms_t'(50);
            cfg_reg.long_press_ms       <= ms_t'(1000);
            cfg_reg.double_click_ms     <= ms_t'(300);
            cfg_reg.double_click_enable <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DEBOUNCE_MS:   cfg_reg.debounce_ms         <= cfg_wr_data;
                REG_LONG_PRESS_MS: cfg_reg.long_press_ms       <= cfg_wr_data;
                REG_DOUBLE_MS:     cfg_reg.double_click_ms     <= cfg_wr_data;
                REG_DOUBLE_EN:     cfg_reg.double_click_enable <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/bcc_classify.sv]
// Press classification state machine: one scan per fire strobe.
module bcc_classify (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  logic                 pin_level,
    input  bcc_pkg::time_t       now,
    input  bcc_pkg::cfg_t        cfg,
    output logic                 ev_valid,
    output bcc_pkg::event_kind_t ev_kind
);
    import bcc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_PRESSED  = 3'd2,
        PH_LONG     = 3'd3,
        PH_RELEASED = 3'd4
    } phase_t;

    phase_t phase_reg, phase_next;
    time_t  debounce_start_reg, debounce_start_next;
    time_t  press_start_reg, press_start_next;
    time_t  last_click_reg, last_click_next;
    logic   long_sent_reg, long_sent_next;

    logic  pressed;
    time_t since_debounce, since_press, since_click;

    assign pressed        = ~pin_level;
    assign since_debounce = now - debounce_start_reg;
    assign since_press    = now - press_start_reg;
    assign since_click    = now - last_click_reg;

    always_comb begin
        phase_next          = phase_reg;
        debounce_start_next = debounce_start_reg;
        press_start_next    = press_start_reg;
        last_click_next     = last_click_reg;
        long_sent_next      = long_sent_reg;
        ev_valid            = 1'b0;
        ev_kind             = EV_SHORT;
        unique case (phase_reg)
            PH_DEBOUNCE: begin
                if (pressed) begin
                    if (since_debounce >= ms_to_time(cfg.debounce_ms)) begin
                        phase_next       = PH_PRESSED;
                        press_start_next = now;
                        long_sent_next   = 1'b0;
                    end
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_PRESSED: begin
                if (pressed) begin
                    if (!long_sent_reg &&
                        since_press >= ms_to_time(cfg.long_press_ms)) begin
                        phase_next     = PH_LONG;
                        long_sent_next = 1'b1;
                        ev_valid       = 1'b1;
                        ev_kind        = EV_LONG;
                    end
                end else begin
                    phase_next = PH_RELEASED;
                end
            end
            PH_LONG: begin
                if (!pressed) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_RELEASED: begin
                // pin ignored on this scan
                if (!long_sent_reg) begin
                    if (since_click < ms_to_time(cfg.double_click_ms)) begin
                        ev_valid = cfg.double_click_enable;
                        ev_kind  = EV_DOUBLE;
                    end else begin
                        last_click_next = now;
                        ev_valid        = 1'b1;
                        ev_kind         = EV_SHORT;
                    end
                end
                phase_next = PH_IDLE;
            end
            default: begin
                // idle, and unused codes behave as idle
                phase_next = PH_IDLE;
                if (pressed) begin
                    phase_next          = PH_DEBOUNCE;
                    debounce_start_next = now;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            debounce_start_reg <= '0;
            press_start_reg    <= '0;
            last_click_reg     <= '0;
            long_sent_reg      <= 1'b0;
        end else if (fire) begin
            phase_reg          <= phase_next;
            debounce_start_reg <= debounce_start_next;
            press_start_reg    <= press_start_next;
            last_click_reg     <= last_click_next;
            long_sent_reg      <= long_sent_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_long_from_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev_valid && ev_kind == EV_LONG) |-> (phase_reg == PH_PRESSED))
        else $error("long event outside pressed phase");

    a_long_marks_sent: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ev_valid && ev_kind == EV_LONG) |=> long_sent_reg && phase_reg == PH_LONG)
        else $error("long event did not mark the press");

    a_released_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && phase_reg == PH_RELEASED) |=> phase_reg == PH_IDLE)
        else $error("released scan did not return to idle");

    a_click_time_on_short: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ev_valid && ev_kind == EV_SHORT) |=> last_click_reg == $past(now))
        else $error("short click did not record its time");
`endif

endmodule

[rtl/button_click_classifier.sv]
// Top level: input register, classification step and result register.
// An accepted scan waits in the input register until it is classified; its event is then registered onto m_valid.
// Throughput: one scan per cycle while results are taken; a scan that yields no
// event never waits for the result register.
// Reset (aresetn low, synchronous): registers return to 50/1000/300/enabled,
// phase to idle, stored times and the long flag to zero, both stages empty.
module button_click_classifier (
    input  logic                          aclk,
    input  logic                          aresetn,
    // scan input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_pin_level,
    input  logic [bcc_pkg::NOW_BITS-1:0]  s_now_ms,
    // event output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_event_kind,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_addr,
    input  logic [bcc_pkg::MS_BITS-1:0]   cfg_wr_data
);
    import bcc_pkg::*;

    cfg_t cfg;

    // Input stage: holds one scan until the classifier takes it.
    logic                in_valid_reg;
    logic                pin_reg;
    logic [NOW_BITS-1:0] now_reg;

    // Result stage.
    logic        m_valid_reg;
    event_kind_t kind_reg;

    logic        ev_valid;
    event_kind_t ev_kind;
    logic        out_free;
    logic        advance;

    bcc_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (reg_index_t'(cfg_addr)),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // The result register is free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;
    // A scan with no event moves on regardless of the output side.
    assign advance  = in_valid_reg && (!ev_valid || out_free);
    assign s_ready  = !in_valid_reg || advance;

    bcc_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .pin_level (pin_reg),
        .now       (now_to_time(now_reg)),
        .cfg       (cfg),
        .ev_valid  (ev_valid),
        .ev_kind   (ev_kind)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pin_reg <= s_pin_level;
            now_reg <= s_now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && ev_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && ev_valid) begin
            kind_reg <= ev_kind;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = kind_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !(advance && ev_valid))
        else $error("pending event overwritten");

    a_event_needs_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && $past(aresetn)) |=> (!m_valid_reg || $past(advance && ev_valid)))
        else $error("event appeared without a classified scan");

    a_silent_scan_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !ev_valid) |-> s_ready)
        else $error("scan without an event stalled the input");
`endif

endmodule

[bench/button_click_classifier_tb.sv]
// Self-checking testbench for button_click_classifier: random scans against a behavioural model.
module button_click_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int STALL_MAX    = 14;
    // Slowest correct transfer: sender gap, receiver stall and two stages of latency.
    // Taken well over that, so only a hung handshake trips it.
    localparam int HANG_LIMIT   = 2000;
    localparam int SETTLE_TAIL  = 8;

    // Button phases as the predictor tracks them
    typedef enum logic [2:0] {
        BTN_REST      = 3'd0,
        BTN_SETTLING  = 3'd1,
        BTN_HELD      = 3'd2,
        BTN_LONG_HELD = 3'd3,
        BTN_LET_GO    = 3'd4
    } btn_phase_t;

    typedef struct packed {
        logic        pin;
        logic [31:0] now;
    } scan_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_pin_level = 1'b1;
    logic [31:0] s_now_ms    = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_event_kind;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_addr    = '0;
    logic [15:0] cfg_wr_data = '0;

    // Scans waiting to be driven, and events the model says are owed
    scan_t       pending_scans[$];
    event_kind_t expected_events[$];

    // Model's copy of the registers and of the button state (reset values)
    cfg_t        btn_cfg       = '{debounce_ms: 16'd50, long_press_ms: 16'd1000,
                                   double_click_ms: 16'd300, double_click_enable: 1'b1};
    btn_phase_t  btn_phase     = BTN_REST;
    time_t       settle_since  = '0;
    time_t       hold_since    = '0;
    time_t       last_click_at = '0;
    logic        long_fired    = 1'b0;

    // Idling controls, redrawn for each register setting
    logic        scan_idling   = 1'b1;
    logic        result_idling = 1'b1;
    int unsigned scan_wait     = 0;
    int unsigned result_wait   = 0;

    logic [31:0] clock_ms      = '0;
    int unsigned scans_queued  = 0;
    int unsigned scans_sent    = 0;
    int unsigned events_seen   = 0;
    int unsigned settings_used = 1;
    int unsigned failures      = 0;
    int unsigned hang_cycles   = 0;

    button_click_classifier u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pin_level (s_pin_level),
        .s_now_ms    (s_now_ms),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_kind(m_event_kind),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // One accepted scan through the button model; any event it owes is queued.
    // All elapsed times wrap at the time width.
    function automatic void classify_scan(input logic pin, input logic [31:0] now);
        logic  held;
        time_t t;
        held = (pin == 1'b0);
        t    = time_t'(now);
        case (btn_phase)
            BTN_SETTLING: begin
                if (!held) begin
                    btn_phase = BTN_REST;
                end else if (time_t'(t - settle_since) >= time_t'(btn_cfg.debounce_ms)) begin
                    btn_phase  = BTN_HELD;
                    hold_since = t;
                    long_fired = 1'b0;
                end
            end
            BTN_HELD: begin
                if (!held) begin
                    btn_phase = BTN_LET_GO;
                end else if (!long_fired &&
                             time_t'(t - hold_since) >= time_t'(btn_cfg.long_press_ms)) begin
                    btn_phase  = BTN_LONG_HELD;
                    long_fired = 1'b1;
                    expected_events.push_back(EV_LONG);
                end
            end
            BTN_LONG_HELD: begin
                // letting go after a long press is silent
                if (!held)
                    btn_phase = BTN_REST;
            end
            BTN_LET_GO: begin
                // pin ignored here; the scan time alone picks short or double
                if (!long_fired) begin
                    if (time_t'(t - last_click_at) < time_t'(btn_cfg.double_click_ms)) begin
                        // inside the window: click time is kept either way
                        if (btn_cfg.double_click_enable)
                            expected_events.push_back(EV_DOUBLE);
                    end else begin
                        last_click_at = t;
                        expected_events.push_back(EV_SHORT);
                    end
                end
                btn_phase = BTN_REST;
            end
            default: begin
                // idle, and any stray code behaves as idle
                btn_phase = BTN_REST;
                if (held) begin
                    btn_phase    = BTN_SETTLING;
                    settle_since = t;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Scan driver: presents the next queued scan, holds it until the
    // transfer, then waits its drawn gap before the next one. s_valid
    // gets at most one assignment per edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        scan_t next_scan;
        logic  took;
        took = s_valid && s_ready;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            scan_wait <= 0;
        end else begin
            if (took) begin
                // the payload still on the port is the one just transferred
                classify_scan(s_pin_level, s_now_ms);
                scans_sent++;
            end
            if (!s_valid || took) begin
                if (scan_wait != 0) begin
                    scan_wait <= scan_wait - 1;
                    s_valid   <= 1'b0;
                end else if (pending_scans.size() != 0) begin
                    next_scan   = pending_scans.pop_front();
                    s_valid     <= 1'b1;
                    s_pin_level <= next_scan.pin;
                    s_now_ms    <= next_scan.now;
                    scan_wait   <= scan_idling ? $urandom_range(0, STALL_MAX) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Event monitor: checks each transfer against the oldest owed event,
    // then stalls m_ready for a drawn number of cycles.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        event_kind_t want;
        int unsigned stall;
        if (!aresetn) begin
            m_ready     <= 1'b0;
            result_wait <= 0;
        end else if (m_valid && m_ready) begin
            events_seen++;
            if (expected_events.size() == 0) begin
                $error("event_kind: expected no event, got %0d", m_event_kind);
                failures++;
            end else begin
                want = expected_events.pop_front();
                if (m_event_kind !== want) begin
                    $error("event_kind: expected %0d, got %0d", want, m_event_kind);
                    failures++;
                end
            end
            stall = result_idling ? $urandom_range(0, STALL_MAX) : 0;
            m_ready     <= (stall == 0);
            result_wait <= (stall == 0) ? 0 : stall - 1;
        end else if (result_wait != 0) begin
            result_wait <= result_wait - 1;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Hang watchdog: sampled mid-cycle, counts cycles with work outstanding
    // but no transfer about to happen on either channel.
    always @(negedge aclk) begin
        if ((pending_scans.size() != 0 || s_valid || expected_events.size() != 0) &&
            !(s_valid && s_ready) && !(m_valid && m_ready)) begin
            hang_cycles++;
            if (hang_cycles >= HANG_LIMIT) begin
                $display("button_click_classifier_tb failed");
                $finish;
            end
        end else begin
            hang_cycles = 0;
        end
    end

    function automatic void push_scan(input logic pin, input logic [31:0] now);
        pending_scans.push_back('{pin: pin, now: now});
        scans_queued++;
    endfunction

    // Register write; the model's copy follows at once since the block is idle
    task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            REG_DEBOUNCE_MS:   btn_cfg.debounce_ms         = value;
            REG_LONG_PRESS_MS: btn_cfg.long_press_ms       = value;
            REG_DOUBLE_MS:     btn_cfg.double_click_ms     = value;
            default:           btn_cfg.double_click_enable = value[0];
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] debounce, input logic [15:0] long_hold,
                                  input logic [15:0] window, input logic enable);
        write_reg(REG_DEBOUNCE_MS, debounce);
        write_reg(REG_LONG_PRESS_MS, long_hold);
        write_reg(REG_DOUBLE_MS, window);
        // stray upper bits on the enable write must be dropped
        write_reg(REG_DOUBLE_EN, {15'($urandom), enable});
        settings_used++;
    endtask

    // Block idle: every scan transferred, every owed event seen, and the
    // pipeline given time to drain scans that produced nothing.
    task automatic wait_drained();
        while (pending_scans.size() != 0 || s_valid || expected_events.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly well-formed press gestures with random timing around the current
    // thresholds, plus lone scans at arbitrary times as line noise.
    task automatic queue_gestures(input int unsigned quota);
        int unsigned first, kind, hold, scans, k, db, lp, dc;
        logic [31:0] t0;
        @(negedge aclk);
        scan_idling   = ($urandom_range(0, 3) != 0);
        result_idling = ($urandom_range(0, 3) != 0);
        db    = btn_cfg.debounce_ms;
        lp    = btn_cfg.long_press_ms;
        dc    = btn_cfg.double_click_ms;
        first = scans_queued;
        while (scans_queued - first < quota) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                clock_ms = $urandom;
                push_scan(1'($urandom_range(0, 1)), clock_ms);
            end else begin
                case (kind % 3)
                    0:       hold = $urandom_range(0, db);
                    1:       hold = db + $urandom_range(0, lp);
                    default: hold = db + lp + $urandom_range(0, lp / 2 + 8);
                endcase
                if ($urandom_range(0, 2) == 0)
                    push_scan(1'b1, clock_ms);
                t0 = clock_ms + $urandom_range(0, 3);
                push_scan(1'b0, t0);
                scans = $urandom_range(1, 6);
                for (k = 1; k <= scans; k++)
                    // now and then a contact bounce
                    push_scan(($urandom_range(0, 15) == 0), t0 + hold * k / scans);
                clock_ms = t0 + hold + $urandom_range(1, 4);
                push_scan(1'b1, clock_ms);
                clock_ms += $urandom_range(0, dc / 2 + 2);
                push_scan(1'($urandom_range(0, 1)), clock_ms);
                // mostly quick follow-ups so doubles occur; sometimes a long pause
                if ($urandom_range(0, 3) == 0)
                    clock_ms += $urandom_range(0, 3 * dc + 10);
                else
                    clock_ms += $urandom_range(1, dc / 3 + 2);
            end
        end
    endtask

    initial begin
        int unsigned p;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed run at reset settings (50 / 1000 / 300 / enabled)
        @(negedge aclk);
        push_scan(1'b1, 32'd0);           // released level at time zero
        push_scan(1'b0, 32'd10);          // debounce starts
        push_scan(1'b0, 32'd60);          // exactly the debounce time: confirmed
        push_scan(1'b1, 32'd100);         // let go
        push_scan(1'b0, 32'd110);         // first click near zero counts as double; pin ignored
        push_scan(1'b0, 32'd400);
        push_scan(1'b1, 32'd420);         // bounce during debounce drops back to idle
        push_scan(1'b0, 32'd430);
        push_scan(1'b0, 32'd480);
        push_scan(1'b0, 32'd1480);        // held exactly the long time: long event
        push_scan(1'b0, 32'd2000);        // still held, nothing more
        push_scan(1'b1, 32'd2010);        // release after long: silent
        push_scan(1'b0, 32'd2100);
        push_scan(1'b0, 32'd2150);
        push_scan(1'b1, 32'd2200);
        push_scan(1'b1, 32'd2210);        // plain short click
        push_scan(1'b0, 32'hFFFF_FFFF);   // press straddling the time wrap
        push_scan(1'b0, 32'h0000_0031);
        push_scan(1'b1, 32'h0000_0030);
        push_scan(1'b1, 32'h0000_0040);   // short, measured across the wrap
        push_scan(1'b0, 32'h0000_0050);
        push_scan(1'b0, 32'h0000_0090);
        push_scan(1'b1, 32'h0000_00A0);
        push_scan(1'b1, 32'h0000_00B0);   // quick second click: double
        clock_ms = 32'h0000_0100;
        wait_drained();

        // Zero thresholds: met at once, and no double can ever be seen
        apply_settings(16'h0000, 16'h0000, 16'h0000, 1'b1);
        queue_gestures(105);
        wait_drained();

        // Everything at maximum with doubles swallowed
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_gestures(105);
        wait_drained();

        // Assorted small settings where every event kind turns up often (doubles only when enabled)
        for (p = 0; p < 7; p++) begin
            apply_settings(16'($urandom_range(0, 20)), 16'($urandom_range(0, 150)),
                           16'($urandom_range(0, 400)), 1'($urandom_range(0, 1)));
            queue_gestures(105);
            wait_drained();
        end

        repeat (SETTLE_TAIL) @(posedge aclk);
        $display("Ran %0d scans over %0d register settings; %0d events transferred and checked.",
                 scans_sent, settings_used, events_seen);
        if (failures == 0)
            $display("button_click_classifier_tb passed");
        else
            $display("button_click_classifier_tb failed");
        $finish;
    end

endmodule
